>>> sv/mac_learning_table_defines.svh
// assertion macros used by the checker of the mac learning table
`ifndef MAC_LEARNING_TABLE_DEFINES_SVH
`define MAC_LEARNING_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mac learning table check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mac learning table check failed");

`endif

>>> sv/mlt_pkg.sv
package mlt_pkg;

  localparam int MAC_W     = 48;
  localparam int KIND_W    = 2;
  localparam int BIDX_IN_W = 10;
  localparam int HANDLE_W  = 16;
  localparam int COUNT_W   = 13;
  localparam int USED_W    = 11;
  localparam int DEC_W     = 2;
  localparam int QDEPTH    = 2;

  localparam int DEF_SLOTS_PER_BUCKET = 4;
  localparam int DEF_BUCKET_COUNT     = 1024;
  localparam int DEF_HANDLE_BITS      = 16;

  localparam logic [KIND_W-1:0] KIND_LEARN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd2;

  localparam logic [DEC_W-1:0] DEC_DISCARD = 2'd0;
  localparam logic [DEC_W-1:0] DEC_UNICAST = 2'd1;
  localparam logic [DEC_W-1:0] DEC_FLOOD   = 2'd2;
  localparam logic [DEC_W-1:0] DEC_DONE    = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LEARN,
    OP_LOOKUP,
    OP_FORWARD,
    OP_FLOOD
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_t;

  typedef struct packed {
    op_t                  op;
    logic [MAC_W-1:0]     mac;
    logic [BIDX_IN_W-1:0] bucket;
    logic                 tsel;
    logic [HANDLE_W-1:0]  port;
    logic [HANDLE_W-1:0]  group;
    logic [HANDLE_W-1:0]  tag;
  } q_item_t;

  typedef struct packed {
    logic [DEC_W-1:0]    decision;
    logic                hit;
    logic [HANDLE_W-1:0] egress_port;
    logic [HANDLE_W-1:0] egress_group;
    logic [HANDLE_W-1:0] tag;
    logic                main_overflow;
    logic                shadow_overflow;
    logic [COUNT_W-1:0]  main_entry_count;
    logic [USED_W-1:0]   main_used_buckets;
  } res_t;

endpackage

>>> sv/mlt_if.sv
interface mlt_in_if import mlt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [MAC_W-1:0]     mac_address;
  logic [BIDX_IN_W-1:0] bucket_index;
  logic                 which_table;
  logic [HANDLE_W-1:0]  ingress_port;
  logic [HANDLE_W-1:0]  ingress_group;
  logic [HANDLE_W-1:0]  packet_tag;

  modport source (
    output valid, kind, mac_address, bucket_index, which_table,
           ingress_port, ingress_group, packet_tag,
    input  ready
  );
  modport sink (
    input  valid, kind, mac_address, bucket_index, which_table,
           ingress_port, ingress_group, packet_tag,
    output ready
  );
endinterface

interface mlt_out_if import mlt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DEC_W-1:0]    decision;
  logic                hit;
  logic [HANDLE_W-1:0] egress_port;
  logic [HANDLE_W-1:0] egress_group;
  logic [HANDLE_W-1:0] packet_tag_out;
  logic                main_overflow;
  logic                shadow_overflow;
  logic [COUNT_W-1:0]  main_entry_count;
  logic [USED_W-1:0]   main_used_buckets;

  modport source (
    output valid, decision, hit, egress_port, egress_group, packet_tag_out,
           main_overflow, shadow_overflow, main_entry_count, main_used_buckets,
    input  ready
  );
  modport sink (
    input  valid, decision, hit, egress_port, egress_group, packet_tag_out,
           main_overflow, shadow_overflow, main_entry_count, main_used_buckets,
    output ready
  );
endinterface

>>> sv/mlt_front.sv
module mlt_front import mlt_pkg::*; #(
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [MAC_W-1:0]     in_mac,
  input  logic [BIDX_IN_W-1:0] in_bucket,
  input  logic                 in_tsel,
  input  logic [HANDLE_W-1:0]  in_port,
  input  logic [HANDLE_W-1:0]  in_group,
  input  logic [HANDLE_W-1:0]  in_tag,
  input  logic                 clear_busy,
  output logic                 q_valid,
  output q_item_t              q_item,
  input  logic                 q_pop
);

  localparam logic [HANDLE_W-1:0] HMASK = (HANDLE_BITS >= HANDLE_W) ? '1 :
    HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);
  localparam int PTR_W = $clog2(QDEPTH);

  q_item_t              q_mem_r [QDEPTH];
  logic [PTR_W-1:0]     wptr_r, wptr_nxt;
  logic [PTR_W-1:0]     rptr_r, rptr_nxt;
  logic [PTR_W:0]       cnt_r, cnt_nxt;
  q_item_t              cls;
  logic                 push;
  logic                 mac_zero;

  // classify: zero mac never learns or matches, a forward of it floods
  always_comb begin
    mac_zero  = (in_mac == '0);
    cls.mac    = in_mac;
    cls.bucket = in_bucket;
    cls.tsel   = in_tsel;
    cls.port   = in_port & HMASK;
    cls.group  = in_group & HMASK;
    cls.tag    = in_tag;
    case (in_kind)
      KIND_LEARN:   cls.op = mac_zero ? OP_NOP : OP_LEARN;
      KIND_LOOKUP:  cls.op = mac_zero ? OP_NOP : OP_LOOKUP;
      KIND_FORWARD: cls.op = mac_zero ? OP_FLOOD : OP_FORWARD;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != (PTR_W+1)'(QDEPTH)) && !clear_busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = q_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= cls;
    end
  end

endmodule

>>> sv/mlt_back.sv
module mlt_back import mlt_pkg::*; #(
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET,
  parameter int BUCKET_COUNT     = DEF_BUCKET_COUNT,
  parameter int HANDLE_BITS      = DEF_HANDLE_BITS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    clear_busy,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    res
);

  localparam int HS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [HS-1:0]    grp;
    logic [HS-1:0]    prt;
  } slot_t;
  typedef slot_t [SLOTS_PER_BUCKET-1:0] row_t;

  row_t mem_main [BUCKET_COUNT];
  row_t mem_shd  [BUCKET_COUNT];

  back_state_t state_r, state_nxt;
  logic [BW:0]        clr_cnt_r, clr_cnt_nxt;
  q_item_t            item_r;
  row_t               rrow_main_r, rrow_shd_r;
  row_t               wrow_main, wrow_shd;
  logic               wr_en, rd_en;
  logic [BW-1:0]      wr_addr, rd_addr;
  logic               exec_go;

  logic               ovf_main_r, ovf_main_nxt, ovf_shd_r, ovf_shd_nxt;
  logic [COUNT_W-1:0] cnt_main_r, cnt_main_nxt;
  logic [USED_W-1:0]  used_main_r, used_main_nxt;

  logic               out_valid_r;
  logic [DEC_W-1:0]   dec_r, dec_nxt;
  logic               hit_r, hit_nxt;
  logic [HS-1:0]      eprt_r, eprt_nxt, egrp_r, egrp_nxt;
  logic [HANDLE_W-1:0] tag_r;

  logic               fnd_m, fnd_s, fnd_t;
  logic [SW-1:0]      idx_m, idx_s, idx_t;
  row_t               row_t_sel;
  slot_t              hit_slot;
  logic               t_match;
  slot_t              new_slot;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == (BW+1)'(BUCKET_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    exec_go    = (!out_valid_r || out_ready);
    clear_busy = 1'b0;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    case (state_r)
      ST_CLEAR: clear_busy = 1'b1;
      ST_IDLE:  begin
        q_pop = q_valid;
        rd_en = q_valid;
      end
      ST_EXEC:  exec_go = (!out_valid_r || out_ready);
      default:  clear_busy = 1'b1;
    endcase
  end

  assign rd_addr     = BW'(q_item.bucket);
  assign clr_cnt_nxt = (state_r == ST_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;

  // first slot that is empty or holds the mac, in each table
  always_comb begin
    fnd_m = 1'b0;
    idx_m = '0;
    fnd_s = 1'b0;
    idx_s = '0;
    for (int j = SLOTS_PER_BUCKET - 1; j >= 0; j--) begin
      if (rrow_main_r[j].mac == '0 || rrow_main_r[j].mac == item_r.mac) begin
        fnd_m = 1'b1;
        idx_m = SW'(j);
      end
      if (rrow_shd_r[j].mac == '0 || rrow_shd_r[j].mac == item_r.mac) begin
        fnd_s = 1'b1;
        idx_s = SW'(j);
      end
    end
  end

  always_comb begin
    new_slot.mac = item_r.mac;
    new_slot.grp = item_r.group[HS-1:0];
    new_slot.prt = item_r.port[HS-1:0];
    row_t_sel = item_r.tsel ? rrow_shd_r : rrow_main_r;
    fnd_t     = item_r.tsel ? fnd_s : fnd_m;
    idx_t     = item_r.tsel ? idx_s : idx_m;
    hit_slot  = row_t_sel[idx_t];
    t_match   = fnd_t && (hit_slot.mac == item_r.mac);
  end

  // execute: row update, counters, result
  always_comb begin
    wrow_main     = rrow_main_r;
    wrow_shd      = rrow_shd_r;
    ovf_main_nxt  = ovf_main_r;
    ovf_shd_nxt   = ovf_shd_r;
    cnt_main_nxt  = cnt_main_r;
    used_main_nxt = used_main_r;
    dec_nxt       = DEC_DONE;
    hit_nxt       = 1'b0;
    eprt_nxt      = '0;
    egrp_nxt      = '0;
    case (item_r.op)
      OP_LEARN: begin
        if (!fnd_m) begin
          ovf_main_nxt = 1'b1;
        end else if (rrow_main_r[idx_m].mac == item_r.mac) begin
          hit_nxt = 1'b1;
          wrow_main[idx_m].grp = new_slot.grp;
          wrow_main[idx_m].prt = new_slot.prt;
        end else begin
          wrow_main[idx_m] = new_slot;
          cnt_main_nxt     = cnt_main_r + 1'b1;
          if (idx_m == '0) used_main_nxt = used_main_r + 1'b1;
        end
        if (!fnd_s) begin
          ovf_shd_nxt = 1'b1;
        end else if (rrow_shd_r[idx_s].mac == item_r.mac) begin
          wrow_shd[idx_s].grp = new_slot.grp;
          wrow_shd[idx_s].prt = new_slot.prt;
        end else begin
          wrow_shd[idx_s] = new_slot;
        end
      end
      OP_LOOKUP, OP_FORWARD: begin
        if (t_match) begin
          hit_nxt  = 1'b1;
          eprt_nxt = hit_slot.prt;
          egrp_nxt = hit_slot.grp;
          if (item_r.op == OP_FORWARD) begin
            if ((item_r.group != '0 && item_r.group == HANDLE_W'(hit_slot.grp)) ||
                item_r.port == HANDLE_W'(hit_slot.prt)) begin
              dec_nxt = DEC_DISCARD;
            end else begin
              dec_nxt = DEC_UNICAST;
            end
          end
        end else if (item_r.op == OP_FORWARD) begin
          dec_nxt = DEC_FLOOD;
        end
      end
      OP_FLOOD: dec_nxt = DEC_FLOOD;
      default:  dec_nxt = DEC_DONE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = BW'(item_r.bucket);
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[BW-1:0];
    end else if (state_r == ST_EXEC && exec_go && item_r.op == OP_LEARN) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_main[wr_addr] <= (state_r == ST_CLEAR) ? '0 : wrow_main;
      mem_shd[wr_addr]  <= (state_r == ST_CLEAR) ? '0 : wrow_shd;
    end
    if (rd_en) begin
      rrow_main_r <= mem_main[rd_addr];
      rrow_shd_r  <= mem_shd[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      ovf_main_r  <= 1'b0;
      ovf_shd_r   <= 1'b0;
      cnt_main_r  <= '0;
      used_main_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (state_r == ST_EXEC && exec_go) begin
        out_valid_r <= 1'b1;
        ovf_main_r  <= ovf_main_nxt;
        ovf_shd_r   <= ovf_shd_nxt;
        cnt_main_r  <= cnt_main_nxt;
        used_main_r <= used_main_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == ST_EXEC && exec_go) begin
      dec_r  <= dec_nxt;
      hit_r  <= hit_nxt;
      eprt_r <= eprt_nxt;
      egrp_r <= egrp_nxt;
      tag_r  <= item_r.tag;
    end
  end

  // counters load together with the result, so they show the state after it
  assign out_valid             = out_valid_r;
  assign res.decision          = dec_r;
  assign res.hit               = hit_r;
  assign res.egress_port       = HANDLE_W'(eprt_r);
  assign res.egress_group      = HANDLE_W'(egrp_r);
  assign res.tag               = tag_r;
  assign res.main_overflow     = ovf_main_r;
  assign res.shadow_overflow   = ovf_shd_r;
  assign res.main_entry_count  = cnt_main_r;
  assign res.main_used_buckets = used_main_r;

endmodule

>>> sv/mac_learning_table.sv
// Bucketed MAC learning table with a main and a shadow table. Each item
// (learn, lookup, forward) gives one result. A front end classifies items
// into a two-entry queue; the back end handles each item in the states IDLE
// and EXEC: IDLE reads the whole bucket row of both tables into a register,
// EXEC compares all slots, writes the row back on a learn and loads the
// result register once the output is free. A new item is taken only after
// the last one has left EXEC. After reset the back end clears both tables
// one bucket per cycle and takes no item until done.
// BUCKET_COUNT must be a power of two; bucket_index is taken modulo it.
module mac_learning_table import mlt_pkg::*; #(
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET,
  parameter int BUCKET_COUNT     = DEF_BUCKET_COUNT,
  parameter int HANDLE_BITS      = DEF_HANDLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  mlt_in_if.sink    in_ch,
  mlt_out_if.source out_ch
);

  logic    q_valid, q_pop, clear_busy;
  q_item_t q_item;
  res_t    res;

  mlt_front #(
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_mac     (in_ch.mac_address),
    .in_bucket  (in_ch.bucket_index),
    .in_tsel    (in_ch.which_table),
    .in_port    (in_ch.ingress_port),
    .in_group   (in_ch.ingress_group),
    .in_tag     (in_ch.packet_tag),
    .clear_busy (clear_busy),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  mlt_back #(
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .BUCKET_COUNT     (BUCKET_COUNT),
    .HANDLE_BITS      (HANDLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.decision          = res.decision;
  assign out_ch.hit               = res.hit;
  assign out_ch.egress_port       = res.egress_port;
  assign out_ch.egress_group      = res.egress_group;
  assign out_ch.packet_tag_out    = res.tag;
  assign out_ch.main_overflow     = res.main_overflow;
  assign out_ch.shadow_overflow   = res.shadow_overflow;
  assign out_ch.main_entry_count  = res.main_entry_count;
  assign out_ch.main_used_buckets = res.main_used_buckets;

endmodule

>>> sv/mlt_checker.sv
`include "mac_learning_table_defines.svh"

module mlt_checker import mlt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DEC_W-1:0]    out_decision,
  input logic                out_hit,
  input logic [HANDLE_W-1:0] out_egress_port,
  input logic                out_main_overflow,
  input logic [COUNT_W-1:0]  out_main_entry_count,
  input logic [USED_W-1:0]   out_main_used_buckets
);

  `MLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MLT_ASSERT_NEXT(a_ovf_sticky, out_valid && out_main_overflow, !out_valid || out_main_overflow)
  `MLT_ASSERT_NOW(a_known_dest_hit, out_valid && (out_decision == DEC_DISCARD || out_decision == DEC_UNICAST), out_hit)
  `MLT_ASSERT_NOW(a_flood_miss, out_valid && out_decision == DEC_FLOOD, !out_hit && out_egress_port == '0)
  `MLT_ASSERT_NOW(a_used_le_count, out_valid, COUNT_W'(out_main_used_buckets) <= out_main_entry_count)

endmodule

bind mac_learning_table mlt_checker u_mlt_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_decision          (out_ch.decision),
  .out_hit               (out_ch.hit),
  .out_egress_port       (out_ch.egress_port),
  .out_main_overflow     (out_ch.main_overflow),
  .out_main_entry_count  (out_ch.main_entry_count),
  .out_main_used_buckets (out_ch.main_used_buckets)
);
